>>> rtl/assert_macros.svh
// Assertion macros shared by the mailbox RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dmr_pkg.sv
// Types and constants of the doorbell mailbox register block.
`timescale 1ns / 1ps
package dmr_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RELAY = 2'd2;
  localparam logic [1:0] CMD_STUB  = 2'd3;

  localparam logic [11:0] OFS_CTRL   = 12'h000;
  localparam logic [11:0] OFS_SET0   = 12'h008;
  localparam logic [11:0] OFS_CLR0   = 12'h00C;
  localparam logic [11:0] OFS_MASK0  = 12'h010;
  localparam logic [11:0] OFS_STAT0  = 12'h014;
  localparam logic [11:0] OFS_MSTAT0 = 12'h018;
  localparam logic [11:0] OFS_SET1   = 12'h01C;
  localparam logic [11:0] OFS_CLR1   = 12'h020;
  localparam logic [11:0] OFS_MASK1  = 12'h024;
  localparam logic [11:0] OFS_STAT1  = 12'h028;
  localparam logic [11:0] OFS_MSTAT1 = 12'h02C;
  localparam logic [11:0] OFS_MIF    = 12'h06C;
  localparam logic [11:0] OFS_VER    = 12'h070;
  localparam logic [11:0] OFS_SLOT0  = 12'h080;

  // slot numbers derived from a bus offset span 10 bits
  localparam int unsigned SLOT_NUM_W = 10;
  localparam logic [SLOT_NUM_W-1:0] SLOT0_WORD = 10'h020;
  localparam logic [SLOT_NUM_W-1:0] BOOT_SLOT  = 10'd4;
  localparam logic [47:0] SMMU_CTRL_OFS = 48'h20;

  localparam logic [2:0] CFG_STUB_MODE   = 3'd0;
  localparam logic [2:0] CFG_ACK_CHANNEL = 3'd1;
  localparam logic [2:0] CFG_SMMU_BASE   = 3'd2;
  localparam logic [2:0] CFG_MIRROR_BASE = 3'd3;
  localparam logic [2:0] CFG_BOOT_CODE   = 3'd4;

  localparam logic [4:0]  ACK_CHANNEL_RST = 5'd11;
  localparam logic [31:0] BOOT_CODE_RST   = 32'h0000_FB0D;

  typedef struct packed {
    logic        stub_mode;
    logic [4:0]  ack_channel;
    logic [47:0] smmu_base;
    logic [31:0] mirror_base;
    logic [31:0] boot_done_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] addr;
    logic [5:0]  slot_index;
    logic [31:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_group0;
    logic        irq_group1;
    logic        boot_seen;
    logic        mirror_valid;
    logic [31:0] mirror_offset;
    logic [31:0] mirror_value;
    logic        smmu_enable_req;
    logic [47:0] smmu_ctrl_addr;
  } out_item_t;

  // slot number addressed by a bus offset at or above the slot window
  function automatic logic [SLOT_NUM_W-1:0] addr_slot(input logic [11:0] a);
    return a[11:2] - SLOT0_WORD;
  endfunction

endpackage

>>> rtl/dmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/dmr_core.sv
// Register state, slot store and per-item result logic of the mailbox.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dmr_core #(
  parameter int SLOT_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dmr_pkg::cfg_t      cfg,
  input  logic               acc,
  input  dmr_pkg::in_item_t  acc_item,
  input  logic               s1_valid,
  input  dmr_pkg::in_item_t  s1_item,
  input  logic               commit,
  output dmr_pkg::out_item_t res
);
  import dmr_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_NUM_W-1:0] SLOT_LIMIT = SLOT_NUM_W'(SLOT_COUNT);

  logic        soft_r, soft_nxt;
  logic [31:0] pend0_r, pend0_nxt, pend1_r, pend1_nxt;
  logic [31:0] mask0_r, mask0_nxt, mask1_r, mask1_nxt;
  logic [31:0] mif_r, mif_nxt, ver_r, ver_nxt;
  logic        boot_flag_r, boot_nxt;
  logic [SLOT_COUNT-1:0] slot_vld_r;

  // last slot write seen by the read issued at the same edge
  logic                  fwd_v_r;
  logic [IDX_W-1:0]      fwd_idx_r;
  logic [31:0]           fwd_data_r;

  logic [SLOT_NUM_W-1:0] acc_num, s1_num, a_slot, wr_num;
  logic [IDX_W-1:0]      s1_idx;
  logic [31:0]           ram_rdata, slot_q, wr_data, rd;
  logic                  a_in, ch_in, wr_c, mir_v, req;

  // read address: ack slot for bus writes, slot window otherwise
  always_comb begin
    if (acc_item.cmd == CMD_WRITE) begin
      acc_num = {5'd0, cfg.ack_channel};
    end else begin
      acc_num = addr_slot(acc_item.addr);
    end
    if (s1_item.cmd == CMD_WRITE) begin
      s1_num = {5'd0, cfg.ack_channel};
    end else begin
      s1_num = addr_slot(s1_item.addr);
    end
  end

  assign s1_idx = s1_num[IDX_W-1:0];

  dmr_ram #(
    .WIDTH (32),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (commit && wr_c),
    .waddr (wr_num[IDX_W-1:0]),
    .wdata (wr_data),
    .re    (acc),
    .raddr (acc_num[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_v_r && (fwd_idx_r == s1_idx)) begin
      slot_q = fwd_data_r;
    end else if (slot_vld_r[s1_idx]) begin
      slot_q = ram_rdata;
    end else begin
      slot_q = '0;
    end
  end

  assign a_slot = addr_slot(s1_item.addr);
  assign a_in   = (s1_item.addr >= OFS_SLOT0) && (a_slot < SLOT_LIMIT);
  assign ch_in  = ({5'd0, cfg.ack_channel} < SLOT_LIMIT);

  always_comb begin
    soft_nxt  = soft_r;
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    mask0_nxt = mask0_r;
    mask1_nxt = mask1_r;
    mif_nxt   = mif_r;
    ver_nxt   = ver_r;
    boot_nxt  = boot_flag_r;
    rd        = '0;
    wr_c      = 1'b0;
    wr_num    = a_slot;
    wr_data   = s1_item.wdata;
    mir_v     = 1'b0;
    req       = 1'b0;
    case (s1_item.cmd)
      CMD_READ: begin
        case (s1_item.addr)
          OFS_CTRL:                rd = {31'd0, soft_r};
          OFS_SET0, OFS_STAT0:     rd = pend0_r;
          OFS_SET1, OFS_STAT1:     rd = pend1_r;
          OFS_CLR0, OFS_CLR1:      rd = '0;
          OFS_MASK0:               rd = mask0_r;
          OFS_MASK1:               rd = mask1_r;
          OFS_MSTAT0:              rd = pend0_r & ~mask0_r;
          OFS_MSTAT1:              rd = pend1_r & ~mask1_r;
          OFS_MIF:                 rd = mif_r;
          OFS_VER:                 rd = ver_r;
          default: begin
            if (a_in && !cfg.stub_mode) begin
              rd = slot_q;
            end
          end
        endcase
      end
      CMD_WRITE: begin
        case (s1_item.addr)
          OFS_CTRL: begin
            soft_nxt = s1_item.wdata[0];
            if (s1_item.wdata[0]) begin
              pend0_nxt = '0;
              pend1_nxt = '0;
              mask0_nxt = '0;
              mask1_nxt = '0;
            end
          end
          OFS_SET0:  pend0_nxt = pend0_r | s1_item.wdata;
          OFS_SET1: begin
            pend1_nxt = pend1_r | s1_item.wdata;
            // doorbell acknowledge: clear the ack slot, request SMMU enable if a base is set
            if (cfg.stub_mode && s1_item.wdata[cfg.ack_channel] && ch_in &&
                (slot_q == cfg.boot_done_code)) begin
              wr_c    = 1'b1;
              wr_num  = {5'd0, cfg.ack_channel};
              wr_data = '0;
              req     = (cfg.smmu_base != '0);
            end
          end
          OFS_CLR0:  pend0_nxt = pend0_r & ~s1_item.wdata;
          OFS_CLR1:  pend1_nxt = pend1_r & ~s1_item.wdata;
          OFS_MASK0: mask0_nxt = s1_item.wdata;
          OFS_MASK1: mask1_nxt = s1_item.wdata;
          OFS_MIF:   mif_nxt   = s1_item.wdata;
          OFS_VER:   ver_nxt   = s1_item.wdata;
          default: begin
            if (a_in) begin
              wr_c  = 1'b1;
              mir_v = 1'b1;
              if ((a_slot == BOOT_SLOT) && (s1_item.wdata == cfg.boot_done_code)) begin
                boot_nxt = 1'b1;
              end
            end
          end
        endcase
      end
      CMD_RELAY, CMD_STUB: begin
        wr_num = {4'd0, s1_item.slot_index};
        if (wr_num < SLOT_LIMIT) begin
          wr_c  = 1'b1;
          mir_v = (s1_item.cmd == CMD_STUB);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.read_data       = rd;
    res.irq_group0      = |(pend0_nxt & ~mask0_nxt);
    res.irq_group1      = |(pend1_nxt & ~mask1_nxt);
    res.boot_seen       = boot_nxt;
    res.mirror_valid    = mir_v;
    res.mirror_offset   = mir_v ? cfg.mirror_base + {20'd0, wr_num, 2'b00} : '0;
    res.mirror_value    = mir_v ? wr_data : '0;
    res.smmu_enable_req = req;
    res.smmu_ctrl_addr  = req ? cfg.smmu_base + SMMU_CTRL_OFS : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r      <= 1'b0;
      pend0_r     <= '0;
      pend1_r     <= '0;
      mask0_r     <= '0;
      mask1_r     <= '0;
      mif_r       <= '0;
      ver_r       <= '0;
      boot_flag_r <= 1'b0;
      slot_vld_r  <= '0;
      fwd_v_r     <= 1'b0;
    end else begin
      if (commit) begin
        soft_r      <= soft_nxt;
        pend0_r     <= pend0_nxt;
        pend1_r     <= pend1_nxt;
        mask0_r     <= mask0_nxt;
        mask1_r     <= mask1_nxt;
        mif_r       <= mif_nxt;
        ver_r       <= ver_nxt;
        boot_flag_r <= boot_nxt;
        if (wr_c) begin
          slot_vld_r[wr_num[IDX_W-1:0]] <= 1'b1;
        end
      end
      if (acc) begin
        fwd_v_r <= commit && wr_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_idx_r  <= wr_num[IDX_W-1:0];
      fwd_data_r <= wr_data;
    end
  end

  `ASSERT_IMPLIES(a_write_reads_zero, clk, rst_n, s1_valid && (s1_item.cmd != CMD_READ), res.read_data == '0)
  `ASSERT_IMPLIES(a_req_from_ack, clk, rst_n, s1_valid && res.smmu_enable_req, cfg.stub_mode && (s1_item.cmd == CMD_WRITE))
  `ASSERT_NEXT(a_boot_sticky, clk, rst_n, boot_flag_r, boot_flag_r)

endmodule

>>> rtl/doorbell_mailbox_registers.sv
// Top level of the doorbell mailbox register block.
// An accepted item moves from the input register into the result register.
// Throughput: one item per cycle while the result side does not stall; the slot
//   RAM read is issued at accept and used in the following cycle, with a bypass for a write at the same edge.
// Reset (rst_n low, synchronous): configuration returns to its defaults, all
//   group registers and the boot flag clear, slot valid bits clear at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module doorbell_mailbox_registers #(
  parameter int SLOT_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dmr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dmr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [47:0]        cfg_wdata
);
  import dmr_pkg::*;

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;
  logic      acc;
  logic      commit;

  // the item in the input register retires when the result register frees up
  assign commit   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || commit;
  assign acc      = in_valid && in_ready;

  // configuration: plain indexed writes, to be made only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stub_mode      <= 1'b0;
      cfg_r.ack_channel    <= ACK_CHANNEL_RST;
      cfg_r.smmu_base      <= '0;
      cfg_r.mirror_base    <= '0;
      cfg_r.boot_done_code <= BOOT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STUB_MODE:   cfg_r.stub_mode      <= cfg_wdata[0];
        CFG_ACK_CHANNEL: cfg_r.ack_channel    <= cfg_wdata[4:0];
        CFG_SMMU_BASE:   cfg_r.smmu_base      <= cfg_wdata;
        CFG_MIRROR_BASE: cfg_r.mirror_base    <= cfg_wdata[31:0];
        CFG_BOOT_CODE:   cfg_r.boot_done_code <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= in_data;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  dmr_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .acc      (acc),
    .acc_item (in_data),
    .s1_valid (s1_valid_r),
    .s1_item  (s1_item_r),
    .commit   (commit),
    .res      (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, s1_valid_r && !commit, !in_ready)
  `ASSERT_IMPLIES(a_no_frame_zero, clk, rst_n, out_valid_r && !out_data_r.mirror_valid, (out_data_r.mirror_offset == '0) && (out_data_r.mirror_value == '0))
  `ASSERT_IMPLIES(a_no_req_zero, clk, rst_n, out_valid_r && !out_data_r.smmu_enable_req, out_data_r.smmu_ctrl_addr == '0)

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the doorbell mailbox register block.
`timescale 1ns / 1ps
module testbench;
  import dmr_pkg::*;

  localparam int SLOT_COUNT  = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 125;
  // index into calm_mode: which side draws the wait
  localparam int SIDE_SRC  = 0;
  localparam int SIDE_SINK = 1;

  // directed table rows: plain item, item with typed-in result, new settings
  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_t      cfg;
    in_item_t  item;
    out_item_t lit;
  } dir_row_t;

  // rides along with each item: use the typed-in result instead of the model
  typedef struct packed {
    logic      typed;
    out_item_t result;
  } known_result_t;

  localparam logic [11:0] REG_OFS [13] = '{
    OFS_CTRL, OFS_SET0, OFS_CLR0, OFS_MASK0, OFS_STAT0, OFS_MSTAT0,
    OFS_SET1, OFS_CLR1, OFS_MASK1, OFS_STAT1, OFS_MSTAT1, OFS_MIF, OFS_VER
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [47:0] cfg_wdata;

  // Mirror of the block's state, advanced once per accepted item.
  cfg_t        cur_cfg;
  logic [31:0] irq_pend [2];
  logic [31:0] irq_mask [2];
  logic        ctrl_bit;
  logic [31:0] mif_word;
  logic [31:0] ver_word;
  logic [31:0] slot_mem [SLOT_COUNT];
  logic        boot_latched;

  out_item_t     expected_results [$];
  known_result_t known_results [$];
  dir_row_t      dir_rows [$];

  bit calm_mode [2];
  int fail_count  = 0;
  int cycle_count = 0;

  doorbell_mailbox_registers #(
    .SLOT_COUNT(SLOT_COUNT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Small builders
  // ---------------------------------------------------------------------
  function automatic in_item_t req_item(input logic [1:0] c, input logic [11:0] a,
                                        input logic [5:0] s, input logic [31:0] w);
    in_item_t r;
    r.cmd        = c;
    r.addr       = a;
    r.slot_index = s;
    r.wdata      = w;
    return r;
  endfunction

  // typed-in results never carry an SMMU request
  function automatic out_item_t out_lit(input logic [31:0] rd, input logic irq0,
                                        input logic irq1, input logic boot,
                                        input logic mv, input logic [31:0] moff,
                                        input logic [31:0] mval);
    out_item_t r;
    r                 = '0;
    r.read_data       = rd;
    r.irq_group0      = irq0;
    r.irq_group1      = irq1;
    r.boot_seen       = boot;
    r.mirror_valid    = mv;
    r.mirror_offset   = moff;
    r.mirror_value    = mval;
    return r;
  endfunction

  function automatic cfg_t mk_cfg(input logic stub, input logic [4:0] ack,
                                  input logic [47:0] smmu, input logic [31:0] mirror,
                                  input logic [31:0] code);
    cfg_t c;
    c.stub_mode      = stub;
    c.ack_channel    = ack;
    c.smmu_base      = smmu;
    c.mirror_base    = mirror;
    c.boot_done_code = code;
    return c;
  endfunction

  function automatic dir_row_t item_row(input in_item_t it);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.item = it;
    return r;
  endfunction

  function automatic dir_row_t checked_row(input in_item_t it, input out_item_t lit);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CHECKED;
    r.item = it;
    r.lit  = lit;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input cfg_t c);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.cfg  = c;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Mailbox predictor
  // ---------------------------------------------------------------------
  function automatic void slot_write(input int unsigned idx, input logic [31:0] val,
                                     input bit frame, input bit from_bus,
                                     inout out_item_t r);
    if (idx >= SLOT_COUNT) return;
    slot_mem[idx] = val;
    // only a bus write arms the boot flag
    if (from_bus && idx == 32'(BOOT_SLOT) && val == cur_cfg.boot_done_code)
      boot_latched = 1'b1;
    if (frame) begin
      r.mirror_valid  = 1'b1;
      r.mirror_offset = cur_cfg.mirror_base + 32'(idx * 4);
      r.mirror_value  = val;
    end
  endfunction

  function automatic out_item_t mailbox_step(input in_item_t it);
    out_item_t   r;
    logic [31:0] v;
    logic [4:0]  ch;
    int unsigned aw;
    bit          in_window;
    r         = '0;
    v         = it.wdata;
    ch        = cur_cfg.ack_channel;
    aw        = 32'(it.addr);
    in_window = aw >= 32'(OFS_SLOT0) && aw < 32'(OFS_SLOT0) + 4 * SLOT_COUNT;
    case (it.cmd)
      CMD_READ: begin
        case (it.addr)
          OFS_CTRL:             r.read_data = {31'd0, ctrl_bit};
          OFS_SET0, OFS_STAT0:  r.read_data = irq_pend[0];
          OFS_SET1, OFS_STAT1:  r.read_data = irq_pend[1];
          OFS_CLR0, OFS_CLR1:   r.read_data = '0;
          OFS_MASK0:            r.read_data = irq_mask[0];
          OFS_MASK1:            r.read_data = irq_mask[1];
          OFS_MSTAT0:           r.read_data = irq_pend[0] & ~irq_mask[0];
          OFS_MSTAT1:           r.read_data = irq_pend[1] & ~irq_mask[1];
          OFS_MIF:              r.read_data = mif_word;
          OFS_VER:              r.read_data = ver_word;
          default: begin
            // stub mode hides slot contents
            if (in_window && !cur_cfg.stub_mode)
              r.read_data = slot_mem[(aw - 32'(OFS_SLOT0)) >> 2];
          end
        endcase
      end
      CMD_WRITE: begin
        case (it.addr)
          OFS_CTRL: begin
            ctrl_bit = v[0];
            if (v[0]) begin
              irq_pend[0] = '0;
              irq_pend[1] = '0;
              irq_mask[0] = '0;
              irq_mask[1] = '0;
            end
          end
          OFS_SET0: irq_pend[0] |= v;
          OFS_SET1: begin
            irq_pend[1] |= v;
            // doorbell acknowledge: consume the boot code in the ack slot
            if (cur_cfg.stub_mode && v[ch] && slot_mem[ch] == cur_cfg.boot_done_code) begin
              slot_mem[ch] = '0;
              if (cur_cfg.smmu_base != '0) begin
                r.smmu_enable_req = 1'b1;
                r.smmu_ctrl_addr  = cur_cfg.smmu_base + SMMU_CTRL_OFS;
              end
            end
          end
          OFS_CLR0:  irq_pend[0] &= ~v;
          OFS_CLR1:  irq_pend[1] &= ~v;
          OFS_MASK0: irq_mask[0] = v;
          OFS_MASK1: irq_mask[1] = v;
          OFS_MIF:   mif_word = v;
          OFS_VER:   ver_word = v;
          OFS_STAT0, OFS_STAT1, OFS_MSTAT0, OFS_MSTAT1: ;  // read only
          default: begin
            if (in_window) slot_write((aw - 32'(OFS_SLOT0)) >> 2, v, 1'b1, 1'b1, r);
          end
        endcase
      end
      CMD_RELAY: slot_write(32'(it.slot_index), v, 1'b0, 1'b0, r);
      default:   slot_write(32'(it.slot_index), v, 1'b1, 1'b0, r);
    endcase
    r.irq_group0 = |(irq_pend[0] & ~irq_mask[0]);
    r.irq_group1 = |(irq_pend[1] & ~irq_mask[1]);
    r.boot_seen  = boot_latched;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------
  // wait before the next item; now and then a side flips into a no-wait run
  function automatic int draw_wait(input int side);
    if ($urandom_range(0, 39) == 0) calm_mode[side] = !calm_mode[side];
    if (calm_mode[side]) return 0;
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [47:0] pick_extreme(input logic [47:0] hi);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return hi;
      default: return {16'($urandom), $urandom} & hi;
    endcase
  endfunction

  function automatic cfg_t draw_cfg();
    cfg_t c;
    // stub mode mostly on so that doorbell acknowledges can fire
    c.stub_mode      = ($urandom_range(0, 3) != 0);
    c.ack_channel    = 5'(pick_extreme(48'd31));
    c.smmu_base      = pick_extreme('1);
    c.mirror_base    = 32'(pick_extreme(48'hFFFF_FFFF));
    c.boot_done_code = 32'(pick_extreme(48'hFFFF_FFFF));
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return ~(32'd1 << $urandom_range(0, 31));
      4:       return cur_cfg.boot_done_code;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Valid stays high straight into the next item when no gap is drawn, so
  // in_valid is never lowered and raised within one step.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t lit);
    int            gap;
    known_result_t tag;
    gap = draw_wait(SIDE_SRC);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag.typed  = typed;
    tag.result = lit;
    known_results.push_back(tag);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // let every outstanding result drain, plus a margin for the pipeline
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    quiesce();
    for (logic [2:0] r = CFG_STUB_MODE; r <= CFG_BOOT_CODE; r++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= r;
      case (r)
        CFG_STUB_MODE:   cfg_wdata <= 48'(c.stub_mode);
        CFG_ACK_CHANNEL: cfg_wdata <= 48'(c.ack_channel);
        CFG_SMMU_BASE:   cfg_wdata <= c.smmu_base;
        CFG_MIRROR_BASE: cfg_wdata <= 48'(c.mirror_base);
        default:         cfg_wdata <= 48'(c.boot_done_code);
      endcase
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic run_random(input int budget);
    int         sent;
    int         kind;
    logic [4:0] ch;
    in_item_t   it;
    sent = 0;
    while (sent < budget) begin
      kind          = $urandom_range(0, 99);
      it            = '0;
      it.slot_index = 6'($urandom);
      it.wdata      = rand_word();
      ch            = cur_cfg.ack_channel;
      if (kind < 25) begin
        // group and word registers; soft reset has its own, rarer branch
        it.cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        it.addr = REG_OFS[$urandom_range(1, 12)];
        send_item(it, 1'b0, '0);
        sent++;
      end else if (kind < 50) begin
        // slot window through the bus, low address bits random
        it.cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        it.addr = OFS_SLOT0 + 12'($urandom_range(0, 4 * SLOT_COUNT - 1));
        if ($urandom_range(0, 2) == 0) it.wdata = cur_cfg.boot_done_code;
        send_item(it, 1'b0, '0);
        sent++;
      end else if (kind < 65) begin
        it.cmd = $urandom_range(0, 1) ? CMD_RELAY : CMD_STUB;
        if ($urandom_range(0, 1) == 0) it.wdata = cur_cfg.boot_done_code;
        send_item(it, 1'b0, '0);
        sent++;
      end else if (kind < 85) begin
        // doorbell handshake: load the ack slot, ring group 1, read the slot back
        it.wdata = ($urandom_range(0, 9) != 0) ? cur_cfg.boot_done_code : $urandom;
        case ($urandom_range(0, 2))
          0: begin
            it.cmd        = CMD_STUB;
            it.slot_index = {1'b0, ch};
          end
          1: begin
            it.cmd        = CMD_RELAY;
            it.slot_index = {1'b0, ch};
          end
          default: begin
            it.cmd  = CMD_WRITE;
            it.addr = OFS_SLOT0 + {5'd0, ch, 2'b00};
          end
        endcase
        send_item(it, 1'b0, '0);
        it       = req_item(CMD_WRITE, OFS_SET1, 6'($urandom), rand_word());
        if ($urandom_range(0, 9) != 0) it.wdata[ch] = 1'b1;
        send_item(it, 1'b0, '0);
        it = req_item(CMD_READ, OFS_SLOT0 + {5'd0, ch, 2'b00}, 6'($urandom), $urandom);
        send_item(it, 1'b0, '0);
        sent += 3;
      end else if (kind < 90) begin
        it.cmd   = CMD_WRITE;
        it.addr  = OFS_CTRL;
        it.wdata = $urandom;
        send_item(it, 1'b0, '0);
        sent++;
      end else begin
        // noise over the whole input space
        it = req_item(2'($urandom), 12'($urandom), 6'($urandom), $urandom);
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(SIDE_SINK);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // predict at the accepting edge, from the values that edge samples
  always @(posedge clk) begin : accept_track
    known_result_t tag;
    out_item_t     want;
    if (rst_n && in_valid && in_ready) begin
      tag  = known_results.pop_front();
      want = mailbox_step(in_data);
      if (tag.typed) want = tag.result;
      expected_results.push_back(want);
    end
  end

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("read_data", 48'(want.read_data), 48'(out_data.read_data));
        check_field("irq_group0", 48'(want.irq_group0), 48'(out_data.irq_group0));
        check_field("irq_group1", 48'(want.irq_group1), 48'(out_data.irq_group1));
        check_field("boot_seen", 48'(want.boot_seen), 48'(out_data.boot_seen));
        check_field("mirror_valid", 48'(want.mirror_valid), 48'(out_data.mirror_valid));
        check_field("mirror_offset", 48'(want.mirror_offset), 48'(out_data.mirror_offset));
        check_field("mirror_value", 48'(want.mirror_value), 48'(out_data.mirror_value));
        check_field("smmu_enable_req", 48'(want.smmu_enable_req),
                    48'(out_data.smmu_enable_req));
        check_field("smmu_ctrl_addr", want.smmu_ctrl_addr, out_data.smmu_ctrl_addr);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_STUB_MODE;
    cfg_wdata = '0;
    rst_n     = 1'b0;

    // predictor state after reset
    cur_cfg      = mk_cfg(1'b0, ACK_CHANNEL_RST, '0, '0, BOOT_CODE_RST);
    irq_pend[0]  = '0;
    irq_pend[1]  = '0;
    irq_mask[0]  = '0;
    irq_mask[1]  = '0;
    ctrl_bit     = 1'b0;
    mif_word     = '0;
    ver_word     = '0;
    boot_latched = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) slot_mem[i] = '0;

    // Directed part, reset settings first: group registers, boot flag,
    // slot window edges, unmapped and read-only offsets, soft reset.
    dir_rows.push_back(checked_row(req_item(CMD_READ, OFS_CTRL, 6'd0, '0),
                                   out_lit('0, 0, 0, 0, 0, '0, '0)));
    dir_rows.push_back(checked_row(req_item(CMD_WRITE, OFS_SET0, 6'd0, '1),
                                   out_lit('0, 1, 0, 0, 0, '0, '0)));
    dir_rows.push_back(checked_row(req_item(CMD_READ, OFS_STAT0, 6'd0, '0),
                                   out_lit('1, 1, 0, 0, 0, '0, '0)));
    dir_rows.push_back(checked_row(req_item(CMD_WRITE, OFS_MASK0, 6'd0, '1),
                                   out_lit('0, 0, 0, 0, 0, '0, '0)));
    // doorbell bit with stub mode off: no acknowledge
    dir_rows.push_back(checked_row(req_item(CMD_WRITE, OFS_SET1, 6'd0, 32'h0000_0800),
                                   out_lit('0, 0, 1, 0, 0, '0, '0)));
    dir_rows.push_back(checked_row(req_item(CMD_WRITE, OFS_CLR1, 6'd0, 32'h0000_0800),
                                   out_lit('0, 0, 0, 0, 0, '0, '0)));
    // boot code into slot 4 latches the flag and mirrors the write
    dir_rows.push_back(checked_row(req_item(CMD_WRITE, OFS_SLOT0 + 12'h010, 6'd0,
                                            BOOT_CODE_RST),
                                   out_lit('0, 0, 0, 1, 1, 32'h10, BOOT_CODE_RST)));
    dir_rows.push_back(checked_row(req_item(CMD_READ, OFS_SLOT0 + 12'h010, 6'd0, '0),
                                   out_lit(BOOT_CODE_RST, 0, 0, 1, 0, '0, '0)));
    dir_rows.push_back(checked_row(req_item(CMD_WRITE, OFS_SLOT0 + 12'h0FC, 6'd0, '1),
                                   out_lit('0, 0, 0, 1, 1, 32'hFC, '1)));
    dir_rows.push_back(item_row(req_item(CMD_READ, OFS_SLOT0 + 12'h0FF, 6'd0, '0)));
    dir_rows.push_back(item_row(req_item(CMD_RELAY, 12'h000, 6'd11, BOOT_CODE_RST)));
    dir_rows.push_back(item_row(req_item(CMD_STUB, 12'h000, 6'd0, '0)));
    // just past the slot window
    dir_rows.push_back(item_row(req_item(CMD_WRITE, OFS_SLOT0 + 12'h100, 6'd63,
                                         32'h1234_5678)));
    dir_rows.push_back(checked_row(req_item(CMD_READ, OFS_SLOT0 + 12'h100, 6'd63, '0),
                                   out_lit('0, 0, 0, 1, 0, '0, '0)));
    dir_rows.push_back(item_row(req_item(CMD_WRITE, OFS_STAT1, 6'd0, '1)));
    dir_rows.push_back(item_row(req_item(CMD_READ, OFS_STAT1, 6'd0, '0)));
    dir_rows.push_back(item_row(req_item(CMD_WRITE, OFS_MIF, 6'd0, '1)));
    dir_rows.push_back(item_row(req_item(CMD_WRITE, OFS_CTRL, 6'd0, 32'h0000_0001)));
    dir_rows.push_back(checked_row(req_item(CMD_READ, OFS_CTRL, 6'd0, '0),
                                   out_lit(32'h1, 0, 0, 1, 0, '0, '0)));
    dir_rows.push_back(item_row(req_item(CMD_WRITE, OFS_CTRL, 6'd0, '0)));
    dir_rows.push_back(checked_row(req_item(CMD_READ, 12'hFFF, 6'd0, '0),
                                   out_lit('0, 0, 0, 1, 0, '0, '0)));
    // stub mode, top ack channel, all-ones bases: SMMU address wraps
    dir_rows.push_back(cfg_row(mk_cfg(1'b1, 5'd31, '1, '1, '1)));
    dir_rows.push_back(item_row(req_item(CMD_STUB, 12'h000, 6'd31, '1)));
    dir_rows.push_back(item_row(req_item(CMD_WRITE, OFS_SET1, 6'd0, 32'h8000_0000)));
    dir_rows.push_back(item_row(req_item(CMD_READ, OFS_SLOT0 + 12'h07C, 6'd0, '0)));
    // zero SMMU base: acknowledge clears the slot but raises no request
    dir_rows.push_back(cfg_row(mk_cfg(1'b1, 5'd0, '0, 32'h0000_0040, '0)));
    dir_rows.push_back(item_row(req_item(CMD_WRITE, OFS_SET1, 6'd0, 32'h0000_0001)));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:     apply_cfg(dir_rows[i].cfg);
        ROW_CHECKED: send_item(dir_rows[i].item, 1'b1, dir_rows[i].lit);
        default:     send_item(dir_rows[i].item, 1'b0, '0);
      endcase
    end

    // random phases: all-low and all-high settings, then random mixes
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        apply_cfg(mk_cfg(1'b0, 5'd0, '0, '0, '0));
      else if (p == 1)
        apply_cfg(mk_cfg(1'b1, 5'd31, '1, '1, '1));
      else
        apply_cfg(draw_cfg());
      run_random(PHASE_ITEMS);
    end

    quiesce();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/dmr_pkg.sv
rtl/dmr_ram.sv
rtl/dmr_core.sv
rtl/doorbell_mailbox_registers.sv
bench/testbench.sv
